FILE: rtl/strm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strm_pkg
// Shared sizes, codes, memory request types and helper functions of the
// sparse-table range-maximum engine.
// ----------------------------------------------------------------------------
package strm_pkg;

  localparam int DEPTH       = 1024;
  localparam int LEVELS      = 10;
  localparam int SAMPLE_BITS = 32;

  localparam int VALUE_BITS    = 32;
  localparam int OPCODE_BITS   = 2;
  localparam int STATUS_BITS   = 2;
  localparam int POS_BITS      = $clog2(DEPTH);
  localparam int LEN_BITS      = POS_BITS + 1;
  localparam int SPAN_BITS     = LEN_BITS + 1;
  localparam int LVL_BITS      = $clog2(LEVELS + 1);
  localparam int TAB_WORDS     = LEVELS * DEPTH;
  localparam int TAB_ADDR_BITS = $clog2(TAB_WORDS);

  localparam logic [OPCODE_BITS-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_BUILD = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_QUERY = 2'd2;

  localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_BAD   = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_BUILT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LEVEL0,
    S_FETCH,
    S_SAMPLE,
    S_PICK
  } state_t;

  typedef struct packed {
    logic                   we;
    logic [POS_BITS-1:0]    waddr;
    logic [SAMPLE_BITS-1:0] wdata;
    logic [POS_BITS-1:0]    raddr_a;
    logic [POS_BITS-1:0]    raddr_b;
  } samp_req_t;

  typedef struct packed {
    logic                     we;
    logic [TAB_ADDR_BITS-1:0] waddr;
    logic [POS_BITS-1:0]      wdata;
    logic [TAB_ADDR_BITS-1:0] raddr_a;
    logic [TAB_ADDR_BITS-1:0] raddr_b;
  } tab_req_t;

  // Level in the upper bits, position in the lower bits.
  function automatic logic [TAB_ADDR_BITS-1:0] tab_addr(
      input logic [LVL_BITS-1:0] lvl,
      input logic [POS_BITS-1:0] pos);
    return TAB_ADDR_BITS'({lvl, pos});
  endfunction

  function automatic logic [SPAN_BITS-1:0] span_of(input logic [LVL_BITS-1:0] lvl);
    return SPAN_BITS'(1) << lvl;
  endfunction

  // Largest block level that fits in len, capped at the top level.
  function automatic logic [LVL_BITS-1:0] block_level(input logic [LEN_BITS-1:0] len);
    int r;
    r = 0;
    for (int b = 0; b < LEN_BITS; b++) begin
      if (len[b]) r = b;
    end
    if (r > LEVELS - 1) r = LEVELS - 1;
    return LVL_BITS'(r);
  endfunction

  function automatic logic len_too_long(input logic [LEN_BITS-1:0] len);
    logic res;
    res = 1'b0;
    if (LEVELS < LEN_BITS) res = (int'(len) > (1 << LEVELS));
    return res;
  endfunction

endpackage

FILE: rtl/strm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strm_ram
// Synchronous RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module strm_ram #(
  parameter int WIDTH     = 32,
  parameter int WORDS     = 1024,
  parameter int ADDR_BITS = $clog2(WORDS)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr_a,
  input  logic [ADDR_BITS-1:0] raddr_b,
  output logic [WIDTH-1:0]     rdata_a,
  output logic [WIDTH-1:0]     rdata_b
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/strm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strm_ctrl
// Sequencer of the engine: sample loads, level-by-level table build and
// range queries, all through the sample and table memories.
// ----------------------------------------------------------------------------
module strm_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [strm_pkg::OPCODE_BITS-1:0]    opcode,
  input  logic [strm_pkg::POS_BITS-1:0]       sample_index,
  input  logic signed [strm_pkg::VALUE_BITS-1:0] sample_value,
  input  logic [strm_pkg::POS_BITS-1:0]       range_low,
  input  logic [strm_pkg::POS_BITS-1:0]       range_high,
  input  logic                                cfg_we,
  input  logic [strm_pkg::LEN_BITS-1:0]       cfg_wdata,
  output strm_pkg::samp_req_t                 samp_req,
  input  logic [strm_pkg::SAMPLE_BITS-1:0]    samp_rdata_a,
  input  logic [strm_pkg::SAMPLE_BITS-1:0]    samp_rdata_b,
  output strm_pkg::tab_req_t                  tab_req,
  input  logic [strm_pkg::POS_BITS-1:0]       tab_rdata_a,
  input  logic [strm_pkg::POS_BITS-1:0]       tab_rdata_b,
  output logic                                done,
  output logic [strm_pkg::POS_BITS-1:0]       max_position,
  output logic [strm_pkg::STATUS_BITS-1:0]    status
);

  import strm_pkg::*;

  state_t                 state, state_next;
  logic [LEN_BITS-1:0]    n_used;
  logic                   is_query, is_query_next;
  logic [LVL_BITS-1:0]    lvl, lvl_next;
  logic [POS_BITS-1:0]    left_idx, left_idx_next;
  logic [POS_BITS-1:0]    right_idx, right_idx_next;
  logic [POS_BITS-1:0]    left_pos, left_pos_next;
  logic [POS_BITS-1:0]    right_pos, right_pos_next;
  logic [POS_BITS-1:0]    lo, lo_next;
  logic [POS_BITS-1:0]    hi, hi_next;
  logic                   done_next;
  logic [POS_BITS-1:0]    max_position_next;
  logic [STATUS_BITS-1:0] status_next;

  logic [LVL_BITS-1:0]    rd_lvl;
  logic [SPAN_BITS-1:0]   span;
  logic [SPAN_BITS-1:0]   next_span;
  logic [POS_BITS-1:0]    pick_pos;
  logic [LEN_BITS-1:0]    q_len;
  logic [LVL_BITS-1:0]    q_lvl;
  logic                   q_bad;

  assign busy      = (state != S_IDLE);
  assign rd_lvl    = is_query ? lvl : LVL_BITS'(lvl - 1'b1);
  assign span      = span_of(lvl);
  assign next_span = span_of(LVL_BITS'(lvl + 1'b1));
  // Right block wins unless the left sample is strictly larger.
  assign pick_pos  = ($signed(samp_rdata_a) > $signed(samp_rdata_b)) ? left_pos : right_pos;

  assign q_len = LEN_BITS'({1'b0, hi} - {1'b0, lo} + 1'b1);
  assign q_lvl = block_level(q_len);
  assign q_bad = (lo > hi) || ({1'b0, hi} >= n_used) || len_too_long(q_len);

  // Hold the length already clamped to 1..DEPTH.
  always_ff @(posedge clk) begin
    if (rst) begin
      n_used <= LEN_BITS'(1);
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        n_used <= LEN_BITS'(1);
      end else if (int'(cfg_wdata) > DEPTH) begin
        n_used <= LEN_BITS'(DEPTH);
      end else begin
        n_used <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    is_query     <= is_query_next;
    lvl          <= lvl_next;
    left_idx     <= left_idx_next;
    right_idx    <= right_idx_next;
    left_pos     <= left_pos_next;
    right_pos    <= right_pos_next;
    lo           <= lo_next;
    hi           <= hi_next;
    max_position <= max_position_next;
    status       <= status_next;
  end

  always_comb begin
    state_next        = state;
    is_query_next     = is_query;
    lvl_next          = lvl;
    left_idx_next     = left_idx;
    right_idx_next    = right_idx;
    left_pos_next     = left_pos;
    right_pos_next    = right_pos;
    lo_next           = lo;
    hi_next           = hi;
    done_next         = 1'b0;
    max_position_next = max_position;
    status_next       = status;

    samp_req.we      = 1'b0;
    samp_req.waddr   = sample_index;
    samp_req.wdata   = SAMPLE_BITS'(sample_value);
    samp_req.raddr_a = tab_rdata_a;
    samp_req.raddr_b = tab_rdata_b;

    tab_req.we      = 1'b0;
    tab_req.waddr   = tab_addr(lvl, left_idx);
    tab_req.wdata   = pick_pos;
    tab_req.raddr_a = tab_addr(rd_lvl, left_idx);
    tab_req.raddr_b = tab_addr(rd_lvl, right_idx);

    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (opcode)
            OP_LOAD: begin
              samp_req.we = 1'b1;
            end
            OP_BUILD: begin
              is_query_next = 1'b0;
              lvl_next      = '0;
              left_idx_next = '0;
              state_next    = S_LEVEL0;
            end
            OP_QUERY: begin
              is_query_next = 1'b1;
              lo_next       = range_low;
              hi_next       = range_high;
              state_next    = S_CHECK;
            end
            default: begin
            end
          endcase
        end
      end

      S_LEVEL0: begin
        tab_req.we    = 1'b1;
        tab_req.waddr = tab_addr('0, left_idx);
        tab_req.wdata = left_idx;
        if (LEN_BITS'(left_idx) + 1'b1 < n_used) begin
          left_idx_next = left_idx + 1'b1;
        end else if ((LEVELS > 1) && (n_used >= LEN_BITS'(2))) begin
          lvl_next       = LVL_BITS'(1);
          left_idx_next  = '0;
          right_idx_next = POS_BITS'(1);
          state_next     = S_FETCH;
        end else begin
          done_next         = 1'b1;
          max_position_next = '0;
          status_next       = STAT_BUILT;
          state_next        = S_IDLE;
        end
      end

      S_CHECK: begin
        if (q_bad) begin
          done_next         = 1'b1;
          max_position_next = '0;
          status_next       = STAT_BAD;
          state_next        = S_IDLE;
        end else begin
          lvl_next       = q_lvl;
          left_idx_next  = lo;
          right_idx_next = POS_BITS'(SPAN_BITS'(hi) + 1'b1 - span_of(q_lvl));
          state_next     = S_FETCH;
        end
      end

      // Table reads go out on this edge.
      S_FETCH: begin
        state_next = S_SAMPLE;
      end

      // Table data is back: keep the positions, sample reads go out.
      S_SAMPLE: begin
        left_pos_next  = tab_rdata_a;
        right_pos_next = tab_rdata_b;
        state_next     = S_PICK;
      end

      S_PICK: begin
        if (is_query) begin
          done_next         = 1'b1;
          max_position_next = pick_pos;
          status_next       = STAT_OK;
          state_next        = S_IDLE;
        end else begin
          tab_req.we = 1'b1;
          if (SPAN_BITS'(left_idx) + 1'b1 + span <= SPAN_BITS'(n_used)) begin
            left_idx_next  = left_idx + 1'b1;
            right_idx_next = right_idx + 1'b1;
            state_next     = S_FETCH;
          end else if ((int'(lvl) + 1 < LEVELS) && (next_span <= SPAN_BITS'(n_used))) begin
            lvl_next       = LVL_BITS'(lvl + 1'b1);
            left_idx_next  = '0;
            right_idx_next = POS_BITS'(span);
            state_next     = S_FETCH;
          end else begin
            done_next         = 1'b1;
            max_position_next = '0;
            status_next       = STAT_BUILT;
            state_next        = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/sparse_table_range_max.sv
`timescale 1ns / 1ps
// Load: written to the sample store, no result; busy stays low, a load may follow every cycle.
// Query: result strobed after the range check, the serial table read, sample read and
//   compare through the two memories; a bad range is strobed from the check alone.
// Build: level 0 is written first, then each entry of the higher levels goes through
//   the table-read / sample-read / write-back loop.
// Reset: series length returns to 1; memory contents are kept and undefined until written.
// ----------------------------------------------------------------------------
// sparse_table_range_max
// Range-maximum-index engine: sample store, sparse table build and
// overlapping power-of-two block queries.
// ----------------------------------------------------------------------------
module sparse_table_range_max (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [strm_pkg::OPCODE_BITS-1:0]       opcode,
  input  logic [strm_pkg::POS_BITS-1:0]          sample_index,
  input  logic signed [strm_pkg::VALUE_BITS-1:0] sample_value,
  input  logic [strm_pkg::POS_BITS-1:0]          range_low,
  input  logic [strm_pkg::POS_BITS-1:0]          range_high,
  input  logic                                   cfg_we,
  input  logic [strm_pkg::LEN_BITS-1:0]          cfg_wdata,
  output logic                                   done,
  output logic [strm_pkg::POS_BITS-1:0]          max_position,
  output logic [strm_pkg::STATUS_BITS-1:0]       status
);

  import strm_pkg::*;

  samp_req_t              samp_req;
  tab_req_t               tab_req;
  logic [SAMPLE_BITS-1:0] samp_rdata_a;
  logic [SAMPLE_BITS-1:0] samp_rdata_b;
  logic [POS_BITS-1:0]    tab_rdata_a;
  logic [POS_BITS-1:0]    tab_rdata_b;

  strm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .range_low    (range_low),
    .range_high   (range_high),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .samp_req     (samp_req),
    .samp_rdata_a (samp_rdata_a),
    .samp_rdata_b (samp_rdata_b),
    .tab_req      (tab_req),
    .tab_rdata_a  (tab_rdata_a),
    .tab_rdata_b  (tab_rdata_b),
    .done         (done),
    .max_position (max_position),
    .status       (status)
  );

  strm_ram #(
    .WIDTH     (SAMPLE_BITS),
    .WORDS     (DEPTH),
    .ADDR_BITS (POS_BITS)
  ) u_sample_ram (
    .clk     (clk),
    .we      (samp_req.we),
    .waddr   (samp_req.waddr),
    .wdata   (samp_req.wdata),
    .raddr_a (samp_req.raddr_a),
    .raddr_b (samp_req.raddr_b),
    .rdata_a (samp_rdata_a),
    .rdata_b (samp_rdata_b)
  );

  strm_ram #(
    .WIDTH     (POS_BITS),
    .WORDS     (TAB_WORDS),
    .ADDR_BITS (TAB_ADDR_BITS)
  ) u_table_ram (
    .clk     (clk),
    .we      (tab_req.we),
    .waddr   (tab_req.waddr),
    .wdata   (tab_req.wdata),
    .raddr_a (tab_req.raddr_a),
    .raddr_b (tab_req.raddr_b),
    .rdata_a (tab_rdata_a),
    .rdata_b (tab_rdata_b)
  );

endmodule

FILE: sim/sparse_table_range_max_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_table_range_max_tb
// Self-checking bench for the range-maximum engine. Streams length writes and
// load, build and query requests with random spacing, keeps a shadow sample store
// and sparse table to predict each answer, and checks every strobed result in order.
// ----------------------------------------------------------------------------
module sparse_table_range_max_tb;
  import strm_pkg::*;

  localparam logic [OPCODE_BITS-1:0] OP_SPARE = 2'd3;
  localparam logic signed [VALUE_BITS-1:0] MAX_SAMPLE = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] MIN_SAMPLE = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam int RANDOM_ITEMS  = 1350;
  localparam int CALM_AFTER    = 1200;
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES   = 12;
  localparam int QUIET_LIMIT   = 100000;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    bit                           is_cfg;
    logic [LEN_BITS-1:0]          cfg_val;
    logic [OPCODE_BITS-1:0]       op;
    logic [POS_BITS-1:0]          idx;
    logic signed [VALUE_BITS-1:0] val;
    logic [POS_BITS-1:0]          lo;
    logic [POS_BITS-1:0]          hi;
    int                           gap;
  } request_t;

  typedef struct {
    logic [POS_BITS-1:0]    pos;
    logic [STATUS_BITS-1:0] st;
  } answer_t;

  typedef enum logic [2:0] {D_IDLE, D_GAP, D_WAIT, D_DRAIN, D_SETTLE} drive_state_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic [OPCODE_BITS-1:0]       opcode = OP_LOAD;
  logic [POS_BITS-1:0]          sample_index = '0;
  logic signed [VALUE_BITS-1:0] sample_value = '0;
  logic [POS_BITS-1:0]          range_low = '0;
  logic [POS_BITS-1:0]          range_high = '0;
  logic                         cfg_we = 1'b0;
  logic [LEN_BITS-1:0]          cfg_wdata = '0;
  logic                         done;
  logic [POS_BITS-1:0]          max_position;
  logic [STATUS_BITS-1:0]       status;

  // Shadow of the engine state
  logic signed [SAMPLE_BITS-1:0] shadow_samples [DEPTH];
  logic [POS_BITS-1:0]           shadow_table [LEVELS][DEPTH];
  logic [LEN_BITS-1:0]           shadow_length = LEN_BITS'(1);

  answer_t      answer_q [$];
  request_t     stim_q [$];
  request_t     cur;
  drive_state_t drv_state = D_IDLE;
  int           hold_cnt = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;

  // Generator view of what has been written, so no read of an unwritten entry is caused
  bit gen_loaded [DEPTH];
  int gen_len = 1;
  int gen_built = 0;
  int gen_count = 0;
  bit gen_calm = 1'b0;
  bit idle_on = 1'b0;
  int stretch_left = 0;

  sparse_table_range_max uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .range_low    (range_low),
    .range_high   (range_high),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .max_position (max_position),
    .status       (status)
  );

  always #10 clk = ~clk;

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic int used_length(input int raw);
    if (raw < 1) return 1;
    if (raw > DEPTH) return DEPTH;
    return raw;
  endfunction

  // Right wins unless the left sample is strictly larger
  function automatic logic [POS_BITS-1:0] larger_of(input logic [POS_BITS-1:0] l,
                                                    input logic [POS_BITS-1:0] r);
    return (shadow_samples[l] > shadow_samples[r]) ? l : r;
  endfunction

  task automatic predict_range_max(input logic [OPCODE_BITS-1:0] op,
                                   input logic [POS_BITS-1:0] idx,
                                   input logic signed [VALUE_BITS-1:0] val,
                                   input logic [POS_BITS-1:0] lo,
                                   input logic [POS_BITS-1:0] hi);
    int      n;
    int      span_len;
    int      lvl;
    answer_t ans;
    n = used_length(int'(shadow_length));
    ans.pos = '0;
    ans.st = STAT_OK;
    case (op)
      OP_LOAD: shadow_samples[idx] = val;
      OP_BUILD: begin
        for (int i = 0; i < n; i++) shadow_table[0][i] = POS_BITS'(i);
        for (int k = 1; k < LEVELS && (1 << k) <= n; k++) begin
          for (int i = 0; i + (1 << k) <= n; i++)
            shadow_table[k][i] = larger_of(shadow_table[k-1][i],
                                           shadow_table[k-1][i + (1 << (k - 1))]);
        end
        ans.st = STAT_BUILT;
        answer_q.push_back(ans);
      end
      OP_QUERY: begin
        span_len = int'(hi) - int'(lo) + 1;
        if (lo > hi || int'(hi) >= n || span_len > (1 << LEVELS)) begin
          ans.st = STAT_BAD;
        end else begin
          lvl = 0;
          while ((2 << lvl) <= span_len && lvl < LEVELS - 1) lvl++;
          ans.pos = larger_of(shadow_table[lvl][lo],
                              shadow_table[lvl][int'(hi) + 1 - (1 << lvl)]);
        end
        answer_q.push_back(ans);
      end
      default: ;
    endcase
  endtask

  // Extremes, Q16.16 -1/0/+1 to force ties, or anything
  function automatic logic signed [VALUE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return MAX_SAMPLE;
      1: return MIN_SAMPLE;
      2, 3, 4: return VALUE_BITS'((int'($urandom_range(0, 2)) - 1) * 65536);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_request(input logic [OPCODE_BITS-1:0] op, input int idx,
                             input logic signed [VALUE_BITS-1:0] val,
                             input int lo, input int hi);
    request_t r;
    r.is_cfg = 1'b0;
    r.cfg_val = '0;
    r.op = op;
    r.idx = POS_BITS'(idx);
    r.val = val;
    r.lo = POS_BITS'(lo);
    r.hi = POS_BITS'(hi);
    if (stretch_left == 0) begin
      stretch_left = $urandom_range(20, 60);
      idle_on = ($urandom_range(0, 2) != 0);
    end
    stretch_left--;
    r.gap = (!gen_calm && idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
    if (op == OP_LOAD) gen_loaded[idx] = 1'b1;
    stim_q.push_back(r);
    gen_count++;
  endtask

  task automatic add_length(input int raw);
    request_t r;
    r = '{1'b1, LEN_BITS'(raw), OP_LOAD, '0, '0, '0, '0, 0};
    stim_q.push_back(r);
    gen_len = used_length(raw);
  endtask

  // Fill any sample the build would read before it is written
  task automatic add_build();
    for (int i = 0; i < gen_len; i++)
      if (!gen_loaded[i]) add_request(OP_LOAD, i, pick_sample(), 0, 0);
    add_request(OP_BUILD, $urandom_range(0, DEPTH - 1), $urandom,
                $urandom_range(0, DEPTH - 1), $urandom_range(0, DEPTH - 1));
    gen_built = gen_len;
  endtask

  task automatic add_good_query();
    int m;
    int lo;
    int hi;
    int k;
    m = (gen_len < gen_built) ? gen_len : gen_built;
    case ($urandom_range(0, 5))
      0: begin
        lo = $urandom_range(0, m - 1);
        hi = lo;
      end
      1: begin
        lo = 0;
        hi = m - 1;
      end
      2: begin
        k = 0;
        while ((2 << k) <= m) k++;
        k = $urandom_range(0, k);
        lo = $urandom_range(0, m - (1 << k));
        hi = lo + (1 << k) - 1;
      end
      default: begin
        lo = $urandom_range(0, m - 1);
        hi = $urandom_range(lo, m - 1);
      end
    endcase
    add_request(OP_QUERY, $urandom_range(0, DEPTH - 1), $urandom, lo, hi);
  endtask

  task automatic add_bad_query();
    int lo;
    int hi;
    if (gen_len < DEPTH && $urandom_range(0, 1) == 1) begin
      hi = $urandom_range(gen_len, DEPTH - 1);
      lo = $urandom_range(0, hi);
    end else begin
      lo = $urandom_range(1, DEPTH - 1);
      hi = $urandom_range(0, lo - 1);
    end
    add_request(OP_QUERY, $urandom_range(0, DEPTH - 1), $urandom, lo, hi);
  endtask

  task automatic report_mismatch(input string what, input answer_t want);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t ns: %s: expected pos %0d status %0d, got pos %0d status %0d",
               $time, what, want.pos, want.st, max_position, status);
  endtask

  always @(posedge clk) begin : driver
    logic next_start;
    logic next_we;
    bit   fetch;
    next_start = start;
    next_we = 1'b0;
    fetch = 1'b0;
    if (rst) begin
      next_start = 1'b0;
      drv_state = D_IDLE;
      shadow_length = LEN_BITS'(1);
    end else begin
      if (cfg_we) shadow_length = cfg_wdata;
      if (start && !busy) begin
        predict_range_max(opcode, sample_index, sample_value, range_low, range_high);
        next_start = 1'b0;
      end
      case (drv_state)
        D_IDLE: fetch = 1'b1;
        D_GAP: begin
          if (hold_cnt <= 1) begin
            next_start = 1'b1;
            drv_state = D_WAIT;
          end else begin
            hold_cnt--;
          end
        end
        D_WAIT: if (!next_start) fetch = 1'b1;
        D_DRAIN: begin
          // hold the write until every answer is back and the engine is quiet
          if (answer_q.size() == 0 && !busy) begin
            hold_cnt = SETTLE_CYCLES;
            drv_state = D_SETTLE;
          end
        end
        D_SETTLE: begin
          if (hold_cnt == 0) begin
            next_we = 1'b1;
            cfg_wdata <= cur.cfg_val;
            drv_state = D_IDLE;
          end else begin
            hold_cnt--;
          end
        end
        default: drv_state = D_IDLE;
      endcase
      if (fetch) begin
        if (stim_q.size() == 0) begin
          drv_state = D_IDLE;
        end else begin
          cur = stim_q.pop_front();
          if (cur.is_cfg) begin
            drv_state = D_DRAIN;
          end else begin
            opcode <= cur.op;
            sample_index <= cur.idx;
            sample_value <= cur.val;
            range_low <= cur.lo;
            range_high <= cur.hi;
            if (cur.gap == 0) begin
              next_start = 1'b1;
              drv_state = D_WAIT;
            end else begin
              hold_cnt = cur.gap;
              drv_state = D_GAP;
            end
          end
        end
      end
    end
    start <= next_start;
    cfg_we <= next_we;
  end

  always @(posedge clk) begin : monitor
    answer_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done) begin
        if (answer_q.size() == 0) begin
          want = '{'0, '0};
          report_mismatch("result with no request pending", want);
        end else begin
          want = answer_q.pop_front();
          if (max_position !== want.pos || status !== want.st)
            report_mismatch("wrong result", want);
        end
      end
      if (done || (start && !busy) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int raw;
    int burst;
    int pick;
    // Directed: bad ranges before any build, spare opcode, tiny tables, ties, stale table
    add_request(OP_LOAD, 0, MIN_SAMPLE, 0, 0);
    add_request(OP_QUERY, 0, 0, 1, 0);
    add_request(OP_QUERY, 0, 0, 0, 1);
    add_request(OP_QUERY, DEPTH - 1, MAX_SAMPLE, DEPTH - 1, DEPTH - 1);
    add_request(OP_SPARE, DEPTH - 1, -1, DEPTH - 1, 0);
    add_build();
    add_request(OP_QUERY, 0, 0, 0, 0);
    add_length(0);
    add_request(OP_QUERY, 0, 0, 0, 0);
    add_length(5);
    add_request(OP_LOAD, 1, MAX_SAMPLE, 0, 0);
    add_request(OP_LOAD, 2, MAX_SAMPLE, 0, 0);
    add_request(OP_LOAD, 3, -1, 0, 0);
    add_request(OP_LOAD, 4, 0, 0, 0);
    add_build();
    add_request(OP_QUERY, 0, 0, 0, 4);
    add_request(OP_QUERY, 0, 0, 1, 2);
    add_request(OP_QUERY, 0, 0, 3, 4);
    add_request(OP_QUERY, 0, 0, 4, 4);
    add_request(OP_LOAD, 2, MIN_SAMPLE, 0, 0);
    add_request(OP_QUERY, 0, 0, 0, 4);
    add_request(OP_LOAD, DEPTH - 1, MAX_SAMPLE, 0, 0);

    for (int phase = 0; gen_count < RANDOM_ITEMS; phase++) begin
      case (phase)
        1: raw = 2047;
        4: raw = 0;
        9: raw = DEPTH;
        default: begin
          case ($urandom_range(0, 7))
            0: raw = 1;
            1: raw = $urandom_range(2, 8);
            2: raw = $urandom_range(41, 300);
            default: raw = $urandom_range(2, 40);
          endcase
        end
      endcase
      add_length(raw);
      // now and then keep the old table across a length change
      if (phase == 1 || phase == 9 || $urandom_range(0, 5) != 0) add_build();
      burst = $urandom_range(20, 70);
      for (int j = 0; j < burst; j++) begin
        gen_calm = (gen_count >= CALM_AFTER);
        pick = $urandom_range(0, 99);
        if (pick < 45) add_good_query();
        else if (pick < 60) add_bad_query();
        else if (pick < 78)
          add_request(OP_LOAD, $urandom_range(0, gen_len - 1), pick_sample(), 0, 0);
        else if (pick < 85)
          add_request(OP_LOAD, $urandom_range(0, DEPTH - 1), pick_sample(),
                      $urandom_range(0, DEPTH - 1), $urandom_range(0, DEPTH - 1));
        else if (pick < 93) add_build();
        else
          add_request(OP_SPARE, $urandom_range(0, DEPTH - 1), $urandom,
                      $urandom_range(0, DEPTH - 1), $urandom_range(0, DEPTH - 1));
      end
    end

    while (stim_q.size() != 0 || drv_state != D_IDLE || start || answer_q.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && answer_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sparse_table_range_max.f
rtl/strm_pkg.sv
rtl/strm_ram.sv
rtl/strm_ctrl.sv
rtl/sparse_table_range_max.sv
sim/sparse_table_range_max_tb.sv
